// File: hw/rtl/vps_pkg.sv
package vps_pkg;

    localparam int QueueDepth = 16;
    localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW       = $clog2(QueueDepth + 1);

    localparam logic [7:0]  FadeStartDuty = 8'd10;
    localparam logic [7:0]  SpinDuty      = 8'd255;
    localparam logic [31:0] SpinTimeMs    = 32'd100000;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_LOOP    = 2'd1,
        CMD_SPIN    = 2'd2,
        CMD_STOP    = 2'd3
    } vps_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENQ2,
        ST_POP
    } vps_state_t;

    typedef struct packed {
        vps_cmd_t    command;
        logic [31:0] now_ms;
        logic        fade_in;
        logic [7:0]  target_duty;
        logic [19:0] on_length_ms;
        logic [19:0] gap_length_ms;
    } vps_in_t;

    typedef struct packed {
        logic [7:0] pwm_duty;
        logic       is_running;
        logic [4:0] queue_count;
        logic       queue_overflow;
    } vps_out_t;

    // one queued event as stored in the event RAM
    typedef struct packed {
        logic        fade;
        logic [7:0]  duty;
        logic [19:0] length;
    } vps_event_t;

    localparam int EventW = $bits(vps_event_t);

endpackage

// File: hw/rtl/vps_ram.sv
module vps_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
    input  logic [Width-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
    output logic [Width-1:0]                      rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/vibration_pattern_sequencer.sv
// Channel  Handshake              Payload            Moves
// cmd      cmd_valid/cmd_stall    vps_pkg::vps_in_t  one command in
// res      res_valid/res_stall    vps_pkg::vps_out_t one status result out
//
// One command is in flight at a time. Spin, stop, refused enqueues and loops
// that do not pop end in ST_IDLE; an enqueue with a gap adds ST_ENQ2 (the
// event RAM has one write port); a pop adds ST_POP (registered RAM read).
// rst_n clears all control state; the event RAM is not cleared, the fill count
// keeps unwritten entries from being read.
// The result register frees itself in the cycle its transfer completes, so a
// new command is taken in that same cycle; cmd_stall is high while busy.
module vibration_pattern_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  vps_pkg::vps_in_t  cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output vps_pkg::vps_out_t res
);

    vps_pkg::vps_state_t          state_reg, state_next;
    logic [vps_pkg::PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [vps_pkg::PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [vps_pkg::CntW-1:0]     count_reg, count_next;
    logic                         playing_reg, playing_next;
    logic [7:0]                   cur_duty_reg, cur_duty_next;
    logic [7:0]                   goal_duty_reg, goal_duty_next;
    logic [31:0]                  stop_time_reg, stop_time_next;
    logic [7:0]                   written_duty_reg, written_duty_next;
    vps_pkg::vps_in_t             item_reg, item_next;
    vps_pkg::vps_out_t            res_reg, res_next;
    logic                         res_valid_reg, res_valid_next;

    logic                         accept;
    logic                         load_res;
    logic                         overflow;
    logic                         ram_we;
    logic                         ram_re;
    vps_pkg::vps_event_t          ram_wdata;
    vps_pkg::vps_event_t          ram_rdata;
    logic [vps_pkg::CntW:0]       need;

    vps_ram #(
        .Width(vps_pkg::EventW),
        .Depth(vps_pkg::QueueDepth)
    ) u_event_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_ptr_reg),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(rd_ptr_reg),
        .rdata(ram_rdata)
    );

    function automatic logic [vps_pkg::PtrW-1:0] ptr_inc(input logic [vps_pkg::PtrW-1:0] p);
        logic [vps_pkg::PtrW-1:0] r;
        if (p == vps_pkg::PtrW'(vps_pkg::QueueDepth - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + vps_pkg::PtrW'(1);
        end
        return r;
    endfunction

    assign cmd_stall = !((state_reg == vps_pkg::ST_IDLE) && (!res_valid_reg || !res_stall));
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next        = state_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        count_next        = count_reg;
        playing_next      = playing_reg;
        cur_duty_next     = cur_duty_reg;
        goal_duty_next    = goal_duty_reg;
        stop_time_next    = stop_time_reg;
        written_duty_next = written_duty_reg;
        item_next         = item_reg;
        load_res          = 1'b0;
        overflow          = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_wdata         = '0;
        need              = (cmd.gap_length_ms != 20'd0) ? (vps_pkg::CntW+1)'(2)
                                                         : (vps_pkg::CntW+1)'(1);

        case (state_reg)
            vps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = cmd;
                    case (cmd.command)
                        vps_pkg::CMD_ENQUEUE:
                        begin
                            if ({1'b0, count_reg} + need > (vps_pkg::CntW+1)'(vps_pkg::QueueDepth))
                            begin
                                overflow = 1'b1;
                                load_res = 1'b1;
                            end
                            else if (cmd.gap_length_ms != 20'd0)
                            begin
                                // silent gap first, on event follows next cycle
                                ram_we      = 1'b1;
                                ram_wdata   = '{fade: 1'b0, duty: 8'd0,
                                                length: cmd.gap_length_ms};
                                wr_ptr_next = ptr_inc(wr_ptr_reg);
                                count_next  = count_reg + vps_pkg::CntW'(1);
                                state_next  = vps_pkg::ST_ENQ2;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_wdata   = '{fade: cmd.fade_in, duty: cmd.target_duty,
                                                length: cmd.on_length_ms};
                                wr_ptr_next = ptr_inc(wr_ptr_reg);
                                count_next  = count_reg + vps_pkg::CntW'(1);
                                load_res    = 1'b1;
                            end
                        end
                        vps_pkg::CMD_LOOP:
                        begin
                            if (!playing_reg)
                            begin
                                if (count_reg != '0)
                                begin
                                    ram_re     = 1'b1;
                                    state_next = vps_pkg::ST_POP;
                                end
                                else
                                begin
                                    load_res = 1'b1;
                                end
                            end
                            else if (stop_time_reg < cmd.now_ms)
                            begin
                                playing_next      = 1'b0;
                                cur_duty_next     = 8'd0;
                                written_duty_next = 8'd0;
                                load_res          = 1'b1;
                            end
                            else
                            begin
                                if (goal_duty_reg > cur_duty_reg)
                                begin
                                    cur_duty_next = cur_duty_reg + 8'd1;
                                end
                                written_duty_next = cur_duty_next;
                                load_res          = 1'b1;
                            end
                        end
                        vps_pkg::CMD_SPIN:
                        begin
                            stop_time_next = cmd.now_ms + vps_pkg::SpinTimeMs;
                            cur_duty_next  = vps_pkg::SpinDuty;
                            playing_next   = 1'b1;
                            load_res       = 1'b1;
                        end
                        vps_pkg::CMD_STOP:
                        begin
                            stop_time_next = 32'd0;
                            cur_duty_next  = 8'd0;
                            load_res       = 1'b1;
                        end
                        default:
                        begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            vps_pkg::ST_ENQ2:
            begin
                ram_we      = 1'b1;
                ram_wdata   = '{fade: item_reg.fade_in, duty: item_reg.target_duty,
                                length: item_reg.on_length_ms};
                wr_ptr_next = ptr_inc(wr_ptr_reg);
                count_next  = count_reg + vps_pkg::CntW'(1);
                load_res    = 1'b1;
                state_next  = vps_pkg::ST_IDLE;
            end
            vps_pkg::ST_POP:
            begin
                rd_ptr_next    = ptr_inc(rd_ptr_reg);
                count_next     = count_reg - vps_pkg::CntW'(1);
                stop_time_next = item_reg.now_ms + 32'(ram_rdata.length);
                cur_duty_next  = ram_rdata.fade ? vps_pkg::FadeStartDuty : ram_rdata.duty;
                goal_duty_next = ram_rdata.duty;
                playing_next   = 1'b1;
                load_res       = 1'b1;
                state_next     = vps_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vps_pkg::ST_IDLE;
            end
        endcase

        res_next = res_reg;
        if (load_res)
        begin
            res_next.pwm_duty       = written_duty_next;
            res_next.is_running     = playing_next;
            res_next.queue_count    = 5'(count_next);
            res_next.queue_overflow = overflow;
        end

        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= vps_pkg::ST_IDLE;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            count_reg        <= '0;
            playing_reg      <= 1'b0;
            cur_duty_reg     <= 8'd0;
            goal_duty_reg    <= 8'd0;
            stop_time_reg    <= 32'd0;
            written_duty_reg <= 8'd0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            count_reg        <= count_next;
            playing_reg      <= playing_next;
            cur_duty_reg     <= cur_duty_next;
            goal_duty_reg    <= goal_duty_next;
            stop_time_reg    <= stop_time_next;
            written_duty_reg <= written_duty_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vps_pkg::CntW'(vps_pkg::QueueDepth))
        else $error("event count above queue depth");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != vps_pkg::ST_IDLE) |-> cmd_stall)
        else $error("command taken while busy");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vps_pkg::ST_POP) |-> (count_reg != '0) && !playing_reg)
        else $error("pop from empty queue or while playing");

    a_enq2_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vps_pkg::ST_ENQ2) |=> res_valid_reg && !res_reg.queue_overflow
            && (count_reg == $past(count_reg) + vps_pkg::CntW'(1)))
        else $error("second enqueue write did not complete");

    a_result_free_on_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vps_pkg::ST_ENQ2 || state_reg == vps_pkg::ST_POP) |-> !res_valid_reg)
        else $error("result register busy during multi-cycle command");

endmodule

// File: tb/vibration_pattern_sequencer_tb.sv
`timescale 1ns / 100ps

module vibration_pattern_sequencer_tb;

    // Predicts the status word of every command and holds the ones not yet seen.
    class haptic_scoreboard;
        vps_pkg::vps_event_t  event_fifo [vps_pkg::QueueDepth];
        int unsigned          rd_ptr = 0;
        int unsigned          wr_ptr = 0;
        int unsigned          fill = 0;
        bit                   playing = 1'b0;
        bit [7:0]             cur_duty = 8'd0;
        bit [7:0]             goal_duty = 8'd0;
        bit [7:0]             pwm = 8'd0;
        bit [31:0]            stop_ms = 32'd0;
        vps_pkg::vps_out_t    expected_status [$];
        int unsigned          errors = 0;

        function void push_event(bit fade, bit [7:0] duty, bit [19:0] len);
            event_fifo[wr_ptr].fade   = fade;
            event_fifo[wr_ptr].duty   = duty;
            event_fifo[wr_ptr].length = len;
            wr_ptr = (wr_ptr + 1) % vps_pkg::QueueDepth;
            fill++;
        endfunction

        function void note_cmd(vps_pkg::vps_in_t c);
            vps_pkg::vps_out_t    r;
            vps_pkg::vps_event_t  ev;
            bit                   refused;
            int unsigned          need;
            refused = 1'b0;
            case (c.command)
                vps_pkg::CMD_ENQUEUE:
                begin
                    need = (c.gap_length_ms != 20'd0) ? 2 : 1;
                    if (fill + need > vps_pkg::QueueDepth)
                        refused = 1'b1;
                    else
                    begin
                        if (c.gap_length_ms != 20'd0)
                            push_event(1'b0, 8'd0, c.gap_length_ms);
                        push_event(c.fade_in, c.target_duty, c.on_length_ms);
                    end
                end
                vps_pkg::CMD_LOOP:
                begin
                    if (!playing)
                    begin
                        // popping loop writes nothing to the PWM channel
                        if (fill > 0)
                        begin
                            ev = event_fifo[rd_ptr];
                            rd_ptr = (rd_ptr + 1) % vps_pkg::QueueDepth;
                            fill--;
                            stop_ms   = c.now_ms + {12'd0, ev.length};
                            cur_duty  = ev.fade ? vps_pkg::FadeStartDuty : ev.duty;
                            goal_duty = ev.duty;
                            playing   = 1'b1;
                        end
                    end
                    else if (stop_ms < c.now_ms)
                    begin
                        playing  = 1'b0;
                        cur_duty = 8'd0;
                        pwm      = 8'd0;
                    end
                    else
                    begin
                        if (goal_duty > cur_duty)
                            cur_duty++;
                        pwm = cur_duty;
                    end
                end
                vps_pkg::CMD_SPIN:
                begin
                    stop_ms  = c.now_ms + vps_pkg::SpinTimeMs;
                    cur_duty = vps_pkg::SpinDuty;
                    playing  = 1'b1;
                end
                default:
                begin
                    stop_ms  = 32'd0;
                    cur_duty = 8'd0;
                end
            endcase
            r.pwm_duty       = pwm;
            r.is_running     = playing;
            r.queue_count    = 5'(fill);
            r.queue_overflow = refused;
            expected_status.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_status(vps_pkg::vps_out_t got);
            vps_pkg::vps_out_t want;
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_status.pop_front();
            compare_field("pwm_duty", 32'(want.pwm_duty), 32'(got.pwm_duty));
            compare_field("is_running", 32'(want.is_running), 32'(got.is_running));
            compare_field("queue_count", 32'(want.queue_count), 32'(got.queue_count));
            compare_field("queue_overflow", 32'(want.queue_overflow),
                          32'(got.queue_overflow));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    vps_pkg::vps_in_t   cmd;
    logic               res_valid;
    logic               res_stall;
    vps_pkg::vps_out_t  res;

    haptic_scoreboard sb;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    bit               long_hold_req = 1'b0;
    bit [31:0]        clock_ms = 32'd0;

    vibration_pattern_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_cmd(input vps_pkg::vps_in_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_cmd(item);
    endtask

    task automatic send_enqueue(input bit fade, input bit [7:0] duty,
                                input bit [19:0] on_len, input bit [19:0] gap_len);
        vps_pkg::vps_in_t it;
        it.command       = vps_pkg::CMD_ENQUEUE;
        it.now_ms        = $urandom;
        it.fade_in       = fade;
        it.target_duty   = duty;
        it.on_length_ms  = on_len;
        it.gap_length_ms = gap_len;
        send_cmd(it);
    endtask

    // loop, spin and stop; the enqueue fields ride along and must be ignored
    task automatic send_timed(input vps_pkg::vps_cmd_t op, input bit [31:0] now);
        vps_pkg::vps_in_t it;
        it.command       = op;
        it.now_ms        = now;
        it.fade_in       = 1'($urandom);
        it.target_duty   = 8'($urandom);
        it.on_length_ms  = 20'($urandom);
        it.gap_length_ms = 20'($urandom);
        send_cmd(it);
    endtask

    function automatic bit [19:0] pick_length();
        if ($urandom_range(99) < 85)
            return 20'($urandom_range(30));
        return 20'($urandom);
    endfunction

    task automatic random_item(input int unsigned enq_pct);
        int unsigned pick;
        int unsigned jump;
        bit [19:0]   gap;
        pick = $urandom_range(99);
        if (pick < enq_pct)
        begin
            case ($urandom_range(2))
                0:       gap = 20'd0;
                1:       gap = 20'($urandom_range(1, 30));
                default: gap = pick_length();
            endcase
            send_enqueue(1'($urandom), 8'($urandom), pick_length(), gap);
        end
        else if (pick < enq_pct + 5)
            send_timed(vps_pkg::CMD_SPIN, clock_ms);
        else if (pick < enq_pct + 11)
            send_timed(vps_pkg::CMD_STOP, $urandom);
        else
        begin
            jump = $urandom_range(99);
            if (jump < 3)
                clock_ms = $urandom;
            else if (jump < 6)
                clock_ms = clock_ms + $urandom_range(150000);
            else
                clock_ms = clock_ms + $urandom_range(3);
            send_timed(vps_pkg::CMD_LOOP, clock_ms);
        end
    endtask

    initial
    begin : result_side
        int unsigned hold_left;
        hold_left = 0;
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                sb.check_status(res);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        int unsigned idle_by_phase [4];
        int unsigned stall_by_phase [4];
        int unsigned enq_pct;
        sb        = new();
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        idle_by_phase  = '{0, 70, 0, 27};
        stall_by_phase = '{0, 0, 70, 27};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle corner cases on an empty queue
        send_timed(vps_pkg::CMD_LOOP, 32'd0);
        send_timed(vps_pkg::CMD_STOP, 32'd0);
        // fading event whose target sits below the fade start
        send_enqueue(1'b1, 8'd5, 20'd3, 20'd0);
        send_enqueue(1'b0, 8'd255, 20'hFFFFF, 20'hFFFFF);
        send_enqueue(1'b0, 8'd0, 20'd0, 20'd1);
        send_timed(vps_pkg::CMD_LOOP, 32'd100);
        send_timed(vps_pkg::CMD_LOOP, 32'd101);
        send_timed(vps_pkg::CMD_LOOP, 32'd104);
        // stop time wraps past 2^32 and ends at once
        send_timed(vps_pkg::CMD_LOOP, 32'hFFFF_FFF0);
        send_timed(vps_pkg::CMD_LOOP, 32'hFFFF_FFF1);
        send_timed(vps_pkg::CMD_LOOP, 32'd5);
        // stop then a loop at time zero keeps playing and ramps from 0
        send_timed(vps_pkg::CMD_STOP, 32'd0);
        send_timed(vps_pkg::CMD_LOOP, 32'd0);
        send_timed(vps_pkg::CMD_LOOP, 32'd1);
        send_timed(vps_pkg::CMD_SPIN, 32'hFFFF_FFFF);
        send_timed(vps_pkg::CMD_LOOP, 32'd50);
        send_timed(vps_pkg::CMD_STOP, 32'd0);
        // fill to the brim, then both kinds of refusal
        repeat (7)
            send_enqueue(1'($urandom), 8'($urandom), 20'($urandom_range(20)), 20'd2);
        send_enqueue(1'b0, 8'd1, 20'd1, 20'd1);
        send_enqueue(1'b1, 8'd2, 20'd1, 20'd0);

        clock_ms = 32'd1000;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            if (phase == 0 || phase == 2)
                long_hold_req = 1'b1;
            for (int round = 0; round < 9; round++)
            begin
                enq_pct = $urandom_range(5, 45);
                repeat (47)
                    random_item(enq_pct);
            end
        end
        cmd_valid <= 1'b0;

        while (sb.expected_status.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_status.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
